// File: design/lmf_pkg.sv
package lmf_pkg;

  // The pattern always arrives as two 64-bit words, so the byte table is fixed.
  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned PAT_BITS  = 8 * PAT_BYTES;

  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW     = 3'd0,
    CFG_PAT_HIGH    = 3'd1,
    CFG_PAT_LEN     = 3'd2,
    CFG_MATCH_CASE  = 3'd3,
    CFG_WHOLE_WORDS = 3'd4
  } lmf_cfg_e;

  // What the front has found out about one text byte.
  typedef struct packed {
    logic newline;
    logic last_byte;
    logic follow_alnum;
    logic hit;
    logic start_alnum;
  } lmf_flags_t;

endpackage

// File: design/lmf_queue.sv
module lmf_queue import lmf_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  input  logic             pop_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d;
  logic [AW-1:0]    rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign ready_o = (cnt_q != CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("front queue holds more entries than it has");

endmodule

// File: design/lmf_front.sv
module lmf_front import lmf_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned COLUMN_BITS = 16,
  parameter int unsigned LINE_BITS   = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             take_i,
  input  logic [7:0]                       text_byte_i,
  input  logic                             end_of_text_i,
  input  logic [63:0]                      pat_low_i,
  input  logic [63:0]                      pat_high_i,
  input  logic [$clog2(MAX_PATTERN+1)-1:0] len_i,
  input  logic                             match_case_i,
  output logic [LINE_BITS-1:0]             item_line_o,
  output logic [COLUMN_BITS-1:0]           item_start_o,
  output lmf_flags_t                       item_flags_o
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CX_W  = COLUMN_BITS + 1;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic exact);
    if (!exact && b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'd32;
    end
    return b;
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  logic [7:0]             hist_q [MAX_PATTERN];
  logic [COLUMN_BITS-1:0] col_q;
  logic [LINE_BITS-1:0]   line_q;

  logic [7:0]             win [MAX_PATTERN+1];
  logic [PAT_BITS-1:0]    pat_vec;
  logic [MAX_PATTERN-1:0] lane_ok;
  logic                   is_nl;
  logic [CX_W-1:0]        col_inc;
  logic [CX_W-1:0]        len_ext;
  logic [CX_W-1:0]        start_full;
  logic                   in_reach;
  logic [LEN_W-1:0]       before_idx;

  assign pat_vec = {pat_high_i, pat_low_i};
  assign is_nl   = (text_byte_i == NEWLINE);

  // Window after this byte is shifted in: the newest byte sits at the front.
  always_comb begin
    win[0] = text_byte_i;
    for (int k = 1; k <= MAX_PATTERN; k++) begin
      win[k] = hist_q[k-1];
    end
  end

  // Lane j holds the byte that must equal pattern byte len-1-j.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_lane
    logic [4:0] pidx;
    logic [7:0] pbyte;
    assign pidx  = 5'(len_i) - 5'(j) - 5'd1;
    assign pbyte = pat_vec[{pidx[3:0], 3'b000} +: 8];
    assign lane_ok[j] = (5'(j) >= 5'(len_i)) ||
                        (fold_byte(win[j], match_case_i) == fold_byte(pbyte, match_case_i));
  end

  assign col_inc    = {1'b0, col_q} + CX_W'(1);
  assign len_ext    = CX_W'(len_i);
  assign in_reach   = (col_inc >= len_ext);
  assign start_full = col_inc - len_ext;

  // Once the column count has saturated the start sits one place nearer the front.
  assign before_idx = (col_q == '1) ? len_i - LEN_W'(1) : len_i;

  assign item_line_o  = line_q;
  assign item_start_o = start_full[COLUMN_BITS-1:0];

  always_comb begin
    item_flags_o.newline      = is_nl;
    item_flags_o.last_byte    = end_of_text_i;
    item_flags_o.follow_alnum = is_alnum(text_byte_i);
    item_flags_o.hit          = !is_nl && in_reach && (&lane_ok);
    item_flags_o.start_alnum  = (start_full[COLUMN_BITS-1:0] != '0) &&
                                (before_idx != '0) && is_alnum(win[before_idx]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        hist_q[k] <= '0;
      end
      col_q  <= '0;
      line_q <= '0;
    end else if (take_i) begin
      if (!is_nl) begin
        hist_q[0] <= text_byte_i;
        for (int k = 1; k < MAX_PATTERN; k++) begin
          hist_q[k] <= hist_q[k-1];
        end
      end
      if (is_nl || end_of_text_i) begin
        col_q <= '0;
      end else if (col_q != '1) begin
        col_q <= col_q + COLUMN_BITS'(1);
      end
      if (end_of_text_i) begin
        line_q <= '0;
      end else if (is_nl && line_q != '1) begin
        line_q <= line_q + LINE_BITS'(1);
      end
    end
  end

endmodule

// File: design/lmf_back.sv
module lmf_back import lmf_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned COLUMN_BITS = 16,
  parameter int unsigned LINE_BITS   = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             head_valid_i,
  input  logic [LINE_BITS-1:0]             head_line_i,
  input  logic [COLUMN_BITS-1:0]           head_start_i,
  input  lmf_flags_t                       head_flags_i,
  output logic                             pop_o,
  input  logic [$clog2(MAX_PATTERN+1)-1:0] len_i,
  input  logic                             whole_words_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [LINE_BITS-1:0]             out_line_o,
  output logic [COLUMN_BITS-1:0]           out_column_o,
  output logic                             out_last_o
);

  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_AW    = 2;
  localparam int unsigned OUT_CW    = 3;
  localparam int unsigned CX_W      = COLUMN_BITS + 1;

  logic                   pend_q, pend_d;
  logic [COLUMN_BITS-1:0] cand_q, cand_d;
  logic                   cand_alnum_q, cand_alnum_d;
  logic [CX_W-1:0]        nfc_q, nfc_d;

  logic [LINE_BITS-1:0]   res_line_q [OUT_DEPTH];
  logic [COLUMN_BITS-1:0] res_col_q  [OUT_DEPTH];
  logic                   res_last_q [OUT_DEPTH];
  logic [OUT_AW-1:0]      wr_q, rd_q;
  logic [OUT_CW-1:0]      cnt_q;

  logic                   r0_v, r1_v;
  logic                   out_pop;
  logic [OUT_CW-1:0]      n_push;
  logic [COLUMN_BITS-1:0] first_col;

  // An item leaves the queue only when both of its possible results fit.
  assign pop_o   = head_valid_i && (cnt_q <= OUT_CW'(OUT_DEPTH - 2));
  assign out_pop = out_valid_o && out_ready_i;

  always_comb begin
    pend_d       = pend_q;
    cand_d       = cand_q;
    cand_alnum_d = cand_alnum_q;
    nfc_d        = nfc_q;
    r0_v         = 1'b0;
    r1_v         = 1'b0;
    if (!head_flags_i.newline) begin
      // The waiting candidate is settled by this byte as its follower.
      if (pend_q) begin
        if (!whole_words_i || (!cand_alnum_q && !head_flags_i.follow_alnum)) begin
          r0_v  = 1'b1;
          nfc_d = {1'b0, cand_q} + CX_W'(len_i);
        end
        pend_d = 1'b0;
      end
      if (head_flags_i.hit && ({1'b0, head_start_i} >= nfc_d)) begin
        pend_d       = 1'b1;
        cand_d       = head_start_i;
        cand_alnum_d = head_flags_i.start_alnum;
      end
    end
    if (head_flags_i.newline || head_flags_i.last_byte) begin
      // The line edge follows whatever is still waiting.
      if (pend_d && (!whole_words_i || !cand_alnum_d)) begin
        r1_v = 1'b1;
      end
      pend_d = 1'b0;
      nfc_d  = '0;
    end
  end

  assign first_col = r0_v ? cand_q : cand_d;
  assign n_push    = pop_o ? (OUT_CW'(r0_v) + OUT_CW'(r1_v)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= 1'b0;
      cand_q       <= '0;
      cand_alnum_q <= 1'b0;
      nfc_q        <= '0;
      wr_q         <= '0;
      rd_q         <= '0;
      cnt_q        <= '0;
    end else begin
      if (pop_o) begin
        pend_q       <= pend_d;
        cand_q       <= cand_d;
        cand_alnum_q <= cand_alnum_d;
        nfc_q        <= nfc_d;
      end
      wr_q  <= wr_q + OUT_AW'(n_push);
      cnt_q <= cnt_q + n_push - OUT_CW'(out_pop);
      if (out_pop) begin
        rd_q <= rd_q + OUT_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && (r0_v || r1_v)) begin
      res_line_q[wr_q] <= head_line_i;
      res_col_q[wr_q]  <= first_col;
      res_last_q[wr_q] <= !(r0_v && r1_v);
    end
    if (pop_o && r0_v && r1_v) begin
      res_line_q[wr_q + OUT_AW'(1)] <= head_line_i;
      res_col_q[wr_q + OUT_AW'(1)]  <= cand_d;
      res_last_q[wr_q + OUT_AW'(1)] <= 1'b1;
    end
  end

  assign out_valid_o  = (cnt_q != '0);
  assign out_line_o   = res_line_q[rd_q];
  assign out_column_o = res_col_q[rd_q];
  assign out_last_o   = res_last_q[rd_q];

  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OUT_CW'(OUT_DEPTH))
    else $error("result buffer overflow");

  a_line_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && (head_flags_i.newline || head_flags_i.last_byte) |=>
      !pend_q && (nfc_q == '0))
    else $error("candidate or start limit survived the end of a line");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> $stable(pend_q) && $stable(nfc_q) && $stable(cand_q))
    else $error("search state changed without a transfer from the queue");

endmodule

// File: design/literal_line_match_finder_top.sv
// Channel  Direction  Handshake                      Payload
// text     in         text_valid_i / text_ready_o    text_byte_i, end_of_text_i
// match    out        match_valid_o / match_ready_i  match_line_o, match_column_o, last_of_run_o
// config   in         cfg_we_i (no wait)             cfg_index_i, cfg_data_i
//
// One text byte is taken per cycle while text_ready_o is high; the back end settles one
// byte per cycle while two result slots are free. A byte that gives two matches needs
// two output transfers. match_valid_o rises once the settling byte has left the queue
// and its result is in the result buffer. Reset clears the byte history, the counters and
// both buffers at once. A stalled output halts the back end once more than two of the four
// result slots are taken; the two-entry queue then fills and text_ready_o drops.
module literal_line_match_finder_top import lmf_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned COLUMN_BITS = 16,
  parameter int unsigned LINE_BITS   = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   text_valid_i,
  output logic                   text_ready_o,
  input  logic [7:0]             text_byte_i,
  input  logic                   end_of_text_i,
  output logic                   match_valid_o,
  input  logic                   match_ready_i,
  output logic [LINE_BITS-1:0]   match_line_o,
  output logic [COLUMN_BITS-1:0] match_column_o,
  output logic                   last_of_run_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [63:0]            cfg_data_i
);

  localparam int unsigned LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int unsigned FLAGS_W = $bits(lmf_flags_t);
  localparam int unsigned ITEM_W  = LINE_BITS + COLUMN_BITS + FLAGS_W;

  logic [63:0] pat_low_q;
  logic [63:0] pat_high_q;
  logic [4:0]  pat_len_q;
  logic        match_case_q;
  logic        whole_words_q;
  logic [LEN_W-1:0] len_eff;

  logic                   take;
  logic [LINE_BITS-1:0]   f_line;
  logic [COLUMN_BITS-1:0] f_start;
  lmf_flags_t             f_flags;
  logic [ITEM_W-1:0]      q_in, q_out;
  logic                   q_valid;
  logic                   q_pop;
  logic [LINE_BITS-1:0]   h_line;
  logic [COLUMN_BITS-1:0] h_start;
  lmf_flags_t             h_flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q     <= '0;
      pat_high_q    <= '0;
      pat_len_q     <= 5'd1;
      match_case_q  <= 1'b1;
      whole_words_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAT_LOW:     pat_low_q     <= cfg_data_i;
        CFG_PAT_HIGH:    pat_high_q    <= cfg_data_i;
        CFG_PAT_LEN:     pat_len_q     <= cfg_data_i[4:0];
        CFG_MATCH_CASE:  match_case_q  <= cfg_data_i[0];
        CFG_WHOLE_WORDS: whole_words_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A length of zero searches for one byte; anything too long is clipped.
  always_comb begin
    if (pat_len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (pat_len_q > 5'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = pat_len_q[LEN_W-1:0];
    end
  end

  assign take = text_valid_i && text_ready_o;

  lmf_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .COLUMN_BITS (COLUMN_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .pat_low_i     (pat_low_q),
    .pat_high_i    (pat_high_q),
    .len_i         (len_eff),
    .match_case_i  (match_case_q),
    .item_line_o   (f_line),
    .item_start_o  (f_start),
    .item_flags_o  (f_flags)
  );

  assign q_in = {f_line, f_start, f_flags};

  lmf_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .data_i  (q_in),
    .ready_o (text_ready_o),
    .valid_o (q_valid),
    .data_o  (q_out),
    .pop_i   (q_pop)
  );

  assign h_line  = q_out[ITEM_W-1 -: LINE_BITS];
  assign h_start = q_out[FLAGS_W +: COLUMN_BITS];
  assign h_flags = lmf_flags_t'(q_out[FLAGS_W-1:0]);

  lmf_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .COLUMN_BITS (COLUMN_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_valid),
    .head_line_i   (h_line),
    .head_start_i  (h_start),
    .head_flags_i  (h_flags),
    .pop_o         (q_pop),
    .len_i         (len_eff),
    .whole_words_i (whole_words_q),
    .out_valid_o   (match_valid_o),
    .out_ready_i   (match_ready_i),
    .out_line_o    (match_line_o),
    .out_column_o  (match_column_o),
    .out_last_o    (last_of_run_o)
  );

endmodule

// File: tb/tb_literal_line_match_finder_top.sv
module tb_literal_line_match_finder_top;
  import lmf_pkg::*;

  localparam int unsigned MAX_PATTERN  = 16;
  localparam int unsigned COLUMN_BITS  = 16;
  localparam int unsigned LINE_BITS    = 20;
  localparam int unsigned HIST         = MAX_PATTERN + 1;
  localparam int unsigned COLUMN_LIMIT = (1 << COLUMN_BITS) - 1;
  localparam int unsigned LINE_LIMIT   = (1 << LINE_BITS) - 1;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_STALL   = 200;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned SEARCHES_PER_PHASE = 5;
  localparam int unsigned TEXT_PER_SEARCH    = 50;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [LINE_BITS-1:0]   match_line;
    logic [COLUMN_BITS-1:0] match_column;
    logic                   last_of_run;
  } match_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   text_valid_i = 1'b0;
  logic                   text_ready_o;
  logic [7:0]             text_byte_i = 8'h00;
  logic                   end_of_text_i = 1'b0;
  logic                   match_valid_o;
  logic                   match_ready_i = 1'b0;
  logic [LINE_BITS-1:0]   match_line_o;
  logic [COLUMN_BITS-1:0] match_column_o;
  logic                   last_of_run_o;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [63:0]            cfg_data_i = '0;

  literal_line_match_finder_top #(
    .MAX_PATTERN(MAX_PATTERN),
    .COLUMN_BITS(COLUMN_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_valid_i  (text_valid_i),
    .text_ready_o  (text_ready_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .match_valid_o (match_valid_o),
    .match_ready_i (match_ready_i),
    .match_line_o  (match_line_o),
    .match_column_o(match_column_o),
    .last_of_run_o (last_of_run_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Search settings as the block holds them.
  logic [63:0] pat_lo = '0;
  logic [63:0] pat_hi = '0;
  logic [4:0]  pat_len = 5'd1;
  bit          exact_case = 1'b1;
  bit          whole_words = 1'b0;

  // Scan state of the line being searched.
  logic [7:0]  recent [HIST];
  int unsigned col_cnt = 0;
  int unsigned line_cnt = 0;
  int unsigned free_col = 0;
  bit          cand_pending = 1'b0;
  int unsigned cand_start = 0;

  text_item_t  text_backlog[$];
  match_t      awaited_matches[$];
  text_item_t  offer;
  match_t      want;
  match_t      got;
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned matches_seen = 0;
  int unsigned error_count = 0;
  int unsigned text_idle_pct = 0;
  int unsigned match_idle_pct = 0;
  int unsigned stall_requests = 0;
  int unsigned stalls_served = 0;
  int unsigned stall_left = 0;
  int unsigned stuck_cycles = 0;
  string       alphabet = "abAB09z -._";

  function automatic int unsigned span();
    if (pat_len == 0) return 1;
    if (pat_len > MAX_PATTERN) return MAX_PATTERN;
    return pat_len;
  endfunction

  function automatic logic [7:0] pattern_at(int unsigned i);
    return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] b);
    if (!exact_case && b >= "A" && b <= "Z") return b + 8'd32;
    return b;
  endfunction

  function automatic bit is_word_char(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  // Settles the pending candidate; the caller has checked that one is pending.
  function automatic bit candidate_accepted(bit follower_clear);
    int unsigned back;
    bit lead_clear;
    cand_pending = 1'b0;
    lead_clear = 1'b1;
    if (whole_words && cand_start != 0) begin
      back = (col_cnt >= cand_start) ? col_cnt - cand_start : HIST;
      if (back >= 1 && back < HIST && is_word_char(recent[back])) lead_clear = 1'b0;
    end
    if (whole_words && !(lead_clear && follower_clear)) return 1'b0;
    free_col = cand_start + span();
    return 1'b1;
  endfunction

  function automatic match_t match_at(int unsigned column);
    match_t m;
    m.match_line   = LINE_BITS'(line_cnt);
    m.match_column = COLUMN_BITS'(column);
    m.last_of_run  = 1'b0;
    return m;
  endfunction

  function automatic void predict_matches(logic [7:0] b, logic eot);
    match_t      found[$];
    int unsigned len;
    int unsigned col;
    int unsigned s;
    bit          hit;
    if (b != NEWLINE) begin
      len = span();
      col = col_cnt;
      if (cand_pending) begin
        if (candidate_accepted(!is_word_char(b))) begin
          found.insert(found.size(), match_at(cand_start));
        end
      end
      for (int i = HIST - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = b;
      if (col_cnt < COLUMN_LIMIT) col_cnt++;
      if (col + 1 >= len) begin
        s = col + 1 - len;
        if (s >= free_col) begin
          hit = 1'b1;
          for (int i = 0; i < len; i++) begin
            if (fold_case(recent[len-1-i]) != fold_case(pattern_at(i))) hit = 1'b0;
          end
          if (hit) begin
            cand_pending = 1'b1;
            cand_start = s;
          end
        end
      end
    end
    if (b == NEWLINE || eot) begin
      // The line edge is a clean follower for whatever is still undecided.
      if (cand_pending) begin
        if (candidate_accepted(1'b1)) found.insert(found.size(), match_at(cand_start));
      end
      col_cnt = 0;
      free_col = 0;
      if (line_cnt < LINE_LIMIT) line_cnt++;
      if (eot) line_cnt = 0;
    end
    if (found.size() != 0) found[found.size()-1].last_of_run = 1'b1;
    foreach (found[k]) awaited_matches.insert(awaited_matches.size(), found[k]);
  endfunction

  function automatic void log_failure(string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", what);
  endfunction

  // Text sender.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_valid_i <= 1'b0;
    end else begin
      if (text_valid_i && text_ready_o) begin
        predict_matches(text_byte_i, end_of_text_i);
        accepted_count++;
      end
      if (!text_valid_i || text_ready_o) begin
        if (text_backlog.size() != 0 && $urandom_range(99) >= text_idle_pct) begin
          offer = text_backlog.pop_front();
          text_valid_i  <= 1'b1;
          text_byte_i   <= offer.text_byte;
          end_of_text_i <= offer.end_of_text;
        end else begin
          text_valid_i <= 1'b0;
        end
      end
    end
  end

  // Match receiver and checker.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_ready_i <= 1'b0;
    end else begin
      if (match_valid_o && match_ready_i) begin
        got.match_line   = match_line_o;
        got.match_column = match_column_o;
        got.last_of_run  = last_of_run_o;
        matches_seen++;
        if (awaited_matches.size() == 0) begin
          log_failure($sformatf("match %0d arrived with none awaited: line %0d col %0d last %0b",
                                matches_seen, got.match_line, got.match_column,
                                got.last_of_run));
        end else begin
          want = awaited_matches.pop_front();
          if (got.match_line !== want.match_line || got.match_column !== want.match_column ||
              got.last_of_run !== want.last_of_run) begin
            log_failure($sformatf("match %0d: want line %0d col %0d last %0b, got %0d %0d %0b",
                                  matches_seen, want.match_line, want.match_column,
                                  want.last_of_run, got.match_line, got.match_column,
                                  got.last_of_run));
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        match_ready_i <= 1'b0;
      end else if (stalls_served != stall_requests) begin
        stalls_served++;
        stall_left = LONG_STALL - 1;
        match_ready_i <= 1'b0;
      end else begin
        match_ready_i <= ($urandom_range(99) >= match_idle_pct);
      end
    end
  end

  // Watchdog: only counts while text or matches are still outstanding.
  always @(posedge clk_i) begin
    if ((text_valid_i && text_ready_o) || (match_valid_o && match_ready_i) ||
        (queued_count == accepted_count && awaited_matches.size() == 0)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_text(logic [7:0] b, logic eot);
    text_item_t item;
    item.text_byte   = b;
    item.end_of_text = eot;
    text_backlog.insert(text_backlog.size(), item);
    queued_count++;
  endtask

  task automatic push_line(string s, bit eot_on_last);
    foreach (s[i]) push_text(s[i], eot_on_last && i == s.len() - 1);
  endtask

  task automatic push_random_text(int unsigned count);
    int unsigned made;
    int unsigned pick;
    logic [7:0]  c;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // A copy of the pattern, with letters in random case when folding.
        for (int i = 0; i < span(); i++) begin
          c = pattern_at(i);
          if (!exact_case && ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) &&
              $urandom_range(1) == 1) c = c ^ 8'h20;
          push_text(c, 1'b0);
        end
        made += span();
      end else begin
        if (pick < 82) c = alphabet[$urandom_range(alphabet.len() - 1)];
        else if (pick < 90) c = NEWLINE;
        else c = (pick == 99) ? NEWLINE : 8'($urandom_range(255));
        push_text(c, pick >= 96);
        made++;
      end
    end
  endtask

  // Returns once every byte has gone in, every match has come out and the
  // block has had time to finish with bytes that give no match.
  task automatic wait_for_quiet();
    while (accepted_count != queued_count || awaited_matches.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Called at a rising edge; the caller lowers the write enable after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_PAT_LOW:     pat_lo = data;
      CFG_PAT_HIGH:    pat_hi = data;
      CFG_PAT_LEN:     pat_len = data[4:0];
      CFG_MATCH_CASE:  exact_case = data[0];
      CFG_WHOLE_WORDS: whole_words = data[0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] noise_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [127:0] text_to_bytes(string s);
    logic [127:0] p;
    p = {noise_word(), noise_word()};
    foreach (s[i]) p[8*i +: 8] = s[i];
    return p;
  endfunction

  function automatic logic [127:0] random_pattern();
    logic [127:0] p;
    p = {noise_word(), noise_word()};
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ($urandom_range(9) < 8) p[8*i +: 8] = alphabet[$urandom_range(alphabet.len() - 1)];
    end
    return p;
  endfunction

  task automatic load_search(logic [127:0] bytes, logic [4:0] len, bit exact, bit words);
    logic [63:0] word;
    write_reg(CFG_PAT_LOW, bytes[63:0]);
    write_reg(CFG_PAT_HIGH, bytes[127:64]);
    word = noise_word();
    word[4:0] = len;
    write_reg(CFG_PAT_LEN, word);
    word = noise_word();
    word[0] = exact;
    write_reg(CFG_MATCH_CASE, word);
    word = noise_word();
    word[0] = words;
    write_reg(CFG_WHOLE_WORDS, word);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [4:0]  len;
    logic [63:0] word;
    foreach (recent[i]) recent[i] = 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    text_idle_pct  = 34;
    match_idle_pct = 78;

    // Settings out of reset: a one-byte pattern of zero, exact compare.
    push_text(8'h00, 1'b0);
    push_text(8'hFF, 1'b0);
    push_text(8'h00, 1'b1);
    wait_for_quiet();

    // Writes to indexes with no register behind them must change nothing.
    // The search load right after them lowers the write enable.
    for (int k = CFG_WHOLE_WORDS + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), noise_word());
    end

    // Folded case with whole words; an end flag on a newline closes one line.
    load_search(text_to_bytes("Ab"), 5'd2, 1'b0, 1'b1);
    push_line("aB ab\n", 1'b0);
    push_line("zab Ab", 1'b1);
    push_line("\n", 1'b1);
    wait_for_quiet();

    // Length zero acts as one; the last byte both decides one match and ends another.
    load_search(text_to_bytes("a"), 5'd0, 1'b1, 1'b0);
    push_line("aa", 1'b1);
    wait_for_quiet();

    // Whole-word mode is switched on while a candidate waits for its follower.
    load_search(text_to_bytes("ab"), 5'd2, 1'b1, 1'b0);
    push_line("xab", 1'b0);
    wait_for_quiet();
    word = noise_word();
    word[0] = 1'b1;
    write_reg(CFG_WHOLE_WORDS, word);
    cfg_we_i <= 1'b0;
    push_line("\n", 1'b0);
    wait_for_quiet();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          text_idle_pct  = 34;
          match_idle_pct = 78;
        end
        1: begin
          text_idle_pct  = 78;
          match_idle_pct = 34;
        end
        default: begin
          text_idle_pct  = 0;
          match_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < SEARCHES_PER_PHASE; s++) begin
        case (s)
          0: len = 5'd1;
          1: len = 5'd16;
          2: len = (phase == 0) ? 5'd0 : 5'($urandom_range(31, MAX_PATTERN + 1));
          default: len = 5'($urandom_range(15, 2));
        endcase
        load_search(random_pattern(), len, bit'((s / 2 + phase) % 2), bit'(s % 2));
        if (phase == 0 && s == 2) begin
          // The sender stops until all matches so far are in.
          push_random_text(TEXT_PER_SEARCH / 2);
          wait_for_quiet();
          push_random_text(TEXT_PER_SEARCH / 2);
        end else begin
          push_random_text(TEXT_PER_SEARCH);
          if (phase == 2 && s == 1) stall_requests++;
        end
        wait_for_quiet();
      end
    end

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
